### design/psd_pkg.sv
// Package for the program stream demultiplexer.
// Holds the classified byte item, the result item, stream mode, route,
// channel and error codes shared by the front end, queue, parser and top level.
package psd_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] TagEnd    = 8'hB9;
  localparam logic [7:0] TagPack   = 8'hBA;
  localparam logic [7:0] TagSystem = 8'hBB;
  localparam logic [7:0] TagFirst  = 8'hBC;
  localparam logic [7:0] AudioLo   = 8'hC0;
  localparam logic [7:0] AudioHi   = 8'hDF;
  localparam logic [7:0] VideoLo   = 8'hE0;
  localparam logic [7:0] VideoHi   = 8'hEF;
  localparam logic [7:0] Mpeg2Mask = 8'hC0;
  localparam logic [7:0] Mpeg2Val  = 8'h40;
  localparam logic [7:0] Mpeg1Mask = 8'hF0;
  localparam logic [7:0] Mpeg1Val  = 8'h20;
  localparam logic [7:0] StuffMask = 8'h07;
  localparam logic [7:0] StuffByte = 8'hFF;

  localparam logic [1:0] ChanAudio = 2'd0;
  localparam logic [1:0] ChanVideo = 2'd1;
  localparam logic [1:0] ChanError = 2'd2;

  localparam int unsigned RegAudioEnable = 0;
  localparam int unsigned RegVideoEnable = 1;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_M1   = 2'd1,
    MODE_M2   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RT_AUDIO = 2'd0,
    RT_VIDEO = 2'd1,
    RT_DROP  = 2'd2
  } route_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_START_CODE = 4'd1,
    ERR_MODE       = 4'd2,
    ERR_MIXED      = 4'd3,
    ERR_NO_PACK    = 4'd4,
    ERR_LEN_SHORT  = 4'd5,
    ERR_LEN_MOD3   = 4'd6,
    ERR_PES_ZERO   = 4'd7,
    ERR_STUFFING   = 4'd8
  } err_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_zero;
    logic       is_one;
    logic       is_ff;
    mode_e      mode;
    logic       in_audio;
    logic       in_video;
    logic       is_end;
    logic       is_pack;
    logic       is_sys;
    logic       ge_bc;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] chan;
    logic       last;
    logic       mpeg2;
    err_e       err;
  } res_t;

  typedef struct packed {
    logic audio_en;
    logic video_en;
  } cfg_t;

endpackage

### design/psd_front.sv
// Front end of the demultiplexer: accepts stream bytes and classifies them.
// Uses psd_pkg; feeds the item queue.
module psd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     stream_byte_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output psd_pkg::item_t push_item_o
);
  import psd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    item_d          = item_q;
    item_d.data     = stream_byte_i;
    item_d.is_zero  = (stream_byte_i == 8'h00);
    item_d.is_one   = (stream_byte_i == 8'h01);
    item_d.is_ff    = (stream_byte_i == StuffByte);
    if ((stream_byte_i & Mpeg2Mask) == Mpeg2Val) begin
      item_d.mode = MODE_M2;
    end else if ((stream_byte_i & Mpeg1Mask) == Mpeg1Val) begin
      item_d.mode = MODE_M1;
    end else begin
      item_d.mode = MODE_NONE;
    end
    item_d.in_audio = (stream_byte_i >= AudioLo) && (stream_byte_i <= AudioHi);
    item_d.in_video = (stream_byte_i >= VideoLo) && (stream_byte_i <= VideoHi);
    item_d.is_end   = (stream_byte_i == TagEnd);
    item_d.is_pack  = (stream_byte_i == TagPack);
    item_d.is_sys   = (stream_byte_i == TagSystem);
    item_d.ge_bc    = (stream_byte_i >= TagFirst);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

### design/psd_queue.sv
// Short item queue between the front end and the parser.
// Uses psd_pkg for the item type; depth is set by the Depth parameter.
module psd_queue #(
  parameter int unsigned Depth = psd_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  psd_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output psd_pkg::item_t pop_item_o
);
  import psd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

### design/psd_parser.sv
// Back end of the demultiplexer: start code, pack, system header and PES parser
// with the output register. Uses psd_pkg; takes items from the queue.
module psd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psd_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  psd_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output psd_pkg::res_t  out_res_o
);
  import psd_pkg::*;

  typedef enum logic [9:0] {
    PH_SC0   = 10'b00_0000_0001,
    PH_SC1   = 10'b00_0000_0010,
    PH_SC2   = 10'b00_0000_0100,
    PH_TAG   = 10'b00_0000_1000,
    PH_HUNT  = 10'b00_0001_0000,
    PH_PACK  = 10'b00_0010_0000,
    PH_STUFF = 10'b00_0100_0000,
    PH_LENHI = 10'b00_1000_0000,
    PH_LENLO = 10'b01_0000_0000,
    PH_BODY  = 10'b10_0000_0000
  } phase_e;

  function automatic logic [1:0] mod3(input logic [15:0] v);
    logic [4:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + {3'b000, v[2*i +: 2]};
    end
    t = {1'b0, s[4:2]} + {2'b00, s[1:0]};
    u = {1'b0, t[3:2]} + {1'b0, t[1:0]};
    if (u >= 3'd6) begin
      u = u - 3'd6;
    end else if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] len_q, len_d;
  logic        sys_q, sys_d;
  mode_e       mode_q, mode_d;
  logic        aud_vld_q, aud_vld_d, vid_vld_q, vid_vld_d;
  logic [7:0]  aud_id_q, aud_id_d, vid_id_q, vid_id_d;
  logic [2:0]  stuff_q, stuff_d;
  route_e      route_q, route_d;
  logic [1:0]  m3_q, m3_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;

  logic        pop, emit, fail;
  err_e        fail_code;
  logic [1:0]  fail_zeros;
  logic [7:0]  b;
  logic [15:0] full_len;
  logic        last;
  logic        offer;
  mode_e       eff_mode;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign pop         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;
  assign b           = in_item_i.data;
  assign full_len    = {len_q[15:8], b};
  assign last        = ({1'b0, cnt_q} + 17'd1) >= {1'b0, len_q};
  assign offer       = (cnt_q >= 16'd6) && (m3_q == 2'd0);

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    sys_d      = sys_q;
    mode_d     = mode_q;
    aud_vld_d  = aud_vld_q;
    vid_vld_d  = vid_vld_q;
    aud_id_d   = aud_id_q;
    vid_id_d   = vid_id_q;
    stuff_d    = stuff_q;
    route_d    = route_q;
    m3_d       = m3_q;
    emit       = 1'b0;
    fail       = 1'b0;
    fail_code  = ERR_NONE;
    fail_zeros = 2'd0;
    eff_mode   = mode_q;
    res_d.data  = b;
    res_d.chan  = route_q;
    res_d.last  = 1'b0;
    res_d.mpeg2 = (mode_q == MODE_M2);
    res_d.err   = ERR_NONE;

    case (phase_q)
      PH_SC0: begin
        if (!in_item_i.is_zero) begin
          fail      = 1'b1;
          fail_code = ERR_START_CODE;
        end else begin
          phase_d = PH_SC1;
        end
      end
      PH_SC1: begin
        if (!in_item_i.is_zero) begin
          fail      = 1'b1;
          fail_code = ERR_START_CODE;
        end else begin
          phase_d = PH_SC2;
        end
      end
      PH_SC2: begin
        if (!in_item_i.is_one) begin
          fail       = 1'b1;
          fail_code  = ERR_START_CODE;
          fail_zeros = in_item_i.is_zero ? 2'd2 : 2'd0;
        end else begin
          phase_d = PH_TAG;
        end
      end
      PH_HUNT: begin
        if (in_item_i.is_zero) begin
          cnt_d = (cnt_q >= 16'd2) ? 16'd2 : cnt_q + 16'd1;
        end else if (in_item_i.is_one && (cnt_q >= 16'd2)) begin
          cnt_d   = '0;
          phase_d = PH_TAG;
        end else begin
          cnt_d = '0;
        end
      end
      PH_TAG: begin
        sys_d   = in_item_i.is_sys;
        route_d = RT_DROP;
        if (aud_vld_q && (aud_id_q == b)) begin
          phase_d = PH_LENHI;
          if (cfg_i.audio_en) begin
            route_d    = RT_AUDIO;
            emit       = 1'b1;
            res_d.chan = ChanAudio;
          end
        end else if (vid_vld_q && (vid_id_q == b)) begin
          phase_d = PH_LENHI;
          if (cfg_i.video_en) begin
            route_d    = RT_VIDEO;
            emit       = 1'b1;
            res_d.chan = ChanVideo;
          end
        end else if (in_item_i.is_end) begin
          aud_vld_d = 1'b0;
          vid_vld_d = 1'b0;
          mode_d    = MODE_NONE;
          phase_d   = PH_SC0;
        end else if (in_item_i.is_pack) begin
          cnt_d   = 16'd4;
          phase_d = PH_PACK;
        end else if (in_item_i.is_sys) begin
          if (mode_q == MODE_NONE) begin
            fail      = 1'b1;
            fail_code = ERR_NO_PACK;
          end else begin
            phase_d = PH_LENHI;
          end
        end else if (in_item_i.ge_bc) begin
          phase_d = PH_LENHI;
        end else begin
          phase_d = PH_SC0;
        end
      end
      PH_PACK: begin
        if (cnt_q == 16'd4) begin
          eff_mode = in_item_i.mode;
          if (in_item_i.mode == MODE_NONE) begin
            fail       = 1'b1;
            fail_code  = ERR_MODE;
            fail_zeros = {1'b0, in_item_i.is_zero};
          end else if ((mode_q != MODE_NONE) && (mode_q != in_item_i.mode)) begin
            fail       = 1'b1;
            fail_code  = ERR_MIXED;
            fail_zeros = {1'b0, in_item_i.is_zero};
          end else begin
            mode_d = in_item_i.mode;
          end
        end
        if ((eff_mode == MODE_M1) && (cnt_q >= 16'd11)) begin
          phase_d = PH_SC0;
        end else if ((eff_mode == MODE_M2) && (cnt_q >= 16'd13)) begin
          stuff_d = b[2:0] & StuffMask[2:0];
          phase_d = ((b & StuffMask) != 8'h00) ? PH_STUFF : PH_SC0;
        end
        cnt_d = cnt_q + 16'd1;
      end
      PH_STUFF: begin
        if (!in_item_i.is_ff) begin
          fail       = 1'b1;
          fail_code  = ERR_STUFFING;
          fail_zeros = {1'b0, in_item_i.is_zero};
        end else begin
          stuff_d = stuff_q - 3'd1;
          if (stuff_q == 3'd1) begin
            phase_d = PH_SC0;
          end
        end
      end
      PH_LENHI: begin
        len_d   = {b, 8'h00};
        phase_d = PH_LENLO;
        emit    = (route_q != RT_DROP);
      end
      PH_LENLO: begin
        len_d = full_len;
        cnt_d = '0;
        m3_d  = 2'd0;
        if (sys_q) begin
          if (full_len < 16'd6) begin
            fail       = 1'b1;
            fail_code  = ERR_LEN_SHORT;
            fail_zeros = {1'b0, in_item_i.is_zero};
          end else if (mod3(full_len) != 2'd0) begin
            fail       = 1'b1;
            fail_code  = ERR_LEN_MOD3;
            fail_zeros = {1'b0, in_item_i.is_zero};
          end else begin
            phase_d = PH_BODY;
          end
        end else if (full_len == 16'd0) begin
          fail       = 1'b1;
          fail_code  = ERR_PES_ZERO;
          fail_zeros = {1'b0, in_item_i.is_zero};
        end else begin
          phase_d = PH_BODY;
          emit    = (route_q != RT_DROP);
        end
      end
      PH_BODY: begin
        cnt_d = cnt_q + 16'd1;
        m3_d  = (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
        if (last) begin
          phase_d = PH_SC0;
        end
        if (sys_q) begin
          if (offer) begin
            if (in_item_i.in_audio && !aud_vld_q) begin
              aud_vld_d = 1'b1;
              aud_id_d  = b;
            end else if (in_item_i.in_video && !vid_vld_q) begin
              vid_vld_d = 1'b1;
              vid_id_d  = b;
            end
          end
        end else if (route_q != RT_DROP) begin
          emit       = 1'b1;
          res_d.last = last;
          if (last) begin
            route_d = RT_DROP;
          end
        end
      end
      default: begin
        phase_d = PH_SC0;
      end
    endcase

    if (fail) begin
      phase_d    = PH_HUNT;
      cnt_d      = {14'd0, fail_zeros};
      route_d    = RT_DROP;
      emit       = 1'b1;
      res_d.data = 8'h00;
      res_d.chan = ChanError;
      res_d.last = 1'b0;
      res_d.err  = fail_code;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SC0;
      cnt_q       <= '0;
      len_q       <= '0;
      sys_q       <= 1'b0;
      mode_q      <= MODE_NONE;
      aud_vld_q   <= 1'b0;
      vid_vld_q   <= 1'b0;
      stuff_q     <= '0;
      route_q     <= RT_DROP;
      m3_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        len_q     <= len_d;
        sys_q     <= sys_d;
        mode_q    <= mode_d;
        aud_vld_q <= aud_vld_d;
        vid_vld_q <= vid_vld_d;
        stuff_q   <= stuff_d;
        route_q   <= route_d;
        m3_q      <= m3_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      aud_id_q <= aud_id_d;
      vid_id_q <= vid_id_d;
      if (emit) begin
        res_q <= res_d;
      end
    end
  end

endmodule

### design/program_stream_demux.sv
// Top level of the MPEG program stream demultiplexer.
// Uses psd_pkg and instantiates psd_front, psd_queue and psd_parser.
//
// The block takes one program stream byte per cycle and sustains that rate
// indefinitely while out_ready_i stays high: each byte passes a classifying
// input register, a short queue and the parser, whose single per-byte state
// update and output register set the figure of one item per clock. Delivered
// packet bytes start with the stream id byte; errors come out on channel 2
// with a code, after which the parser hunts for the next 00 00 01 prefix. The
// two enable registers sit at APB addresses 0x0 (audio) and 0x4 (video); the
// user must see that they are written only while idle, as the block does not enforce it.
module program_stream_demux #(
  parameter int unsigned QueueDepth = psd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  channel_o,
  output logic        last_of_packet_o,
  output logic        is_mpeg2_o,
  output logic [3:0]  error_code_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psd_pkg::*;

  logic  audio_en_q, audio_en_d, video_en_q, video_en_d;
  logic  cfg_write;
  cfg_t  cfg;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;
  res_t  res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg.audio_en = audio_en_q;
  assign cfg.video_en = video_en_q;

  always_comb begin
    audio_en_d = audio_en_q;
    video_en_d = video_en_q;
    if (cfg_write) begin
      if (paddr[2] == 1'(RegAudioEnable)) begin
        audio_en_d = pwdata[0];
      end else begin
        video_en_d = pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'(RegVideoEnable)) begin
      prdata[0] = video_en_q;
    end else begin
      prdata[0] = audio_en_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_en_q <= 1'b1;
      video_en_q <= 1'b1;
    end else begin
      audio_en_q <= audio_en_d;
      video_en_q <= video_en_d;
    end
  end

  psd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  psd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  psd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_item_i   (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign out_byte_o       = res.data;
  assign channel_o        = res.chan;
  assign last_of_packet_o = res.last;
  assign is_mpeg2_o       = res.mpeg2;
  assign error_code_o     = res.err;

endmodule

### tb/program_stream_demux_test.sv
// Self-checking test of the program stream demultiplexer: feeds byte streams
// of packs, system headers, PES packets and damaged items under random idling.
// Depends on psd_pkg and program_stream_demux; expected results come from a parser mirror.
`timescale 1ns / 100ps

module program_stream_demux_test;
  import psd_pkg::*;

  localparam int HalfPeriod = 5;
  localparam int StallLimit = 2000;
  localparam int PhaseBytes = 200;

  typedef enum logic [3:0] {
    P_PFX0, P_PFX1, P_PFX2, P_TAG, P_HUNT, P_PACK, P_STUFF, P_LEN_HI, P_LEN_LO, P_BODY
  } parse_phase_e;

  class demux_mirror;
    logic         audio_en;
    logic         video_en;
    parse_phase_e phase;
    logic [15:0]  cnt;
    logic [15:0]  body_len;
    logic [7:0]   tag;
    mode_e        mode;
    logic [8:0]   audio_sel;
    logic [8:0]   video_sel;
    logic [2:0]   stuff;
    route_e       route;
    res_t         due_outputs[$];
    int unsigned  fails;

    function new();
      audio_en  = 1'b1;
      video_en  = 1'b1;
      phase     = P_PFX0;
      cnt       = '0;
      body_len  = '0;
      tag       = '0;
      mode      = MODE_NONE;
      audio_sel = '0;
      video_sel = '0;
      stuff     = '0;
      route     = RT_DROP;
      fails     = 0;
    endfunction

    function void set_enable(int unsigned idx, logic value);
      if (idx == RegAudioEnable) begin
        audio_en = value;
      end else if (idx == RegVideoEnable) begin
        video_en = value;
      end
    endfunction

    function int unsigned outstanding();
      return due_outputs.size();
    endfunction

    function void deliver(logic [7:0] data, logic [1:0] chan, logic last, err_e err);
      res_t r;
      r.data  = data;
      r.chan  = chan;
      r.last  = last;
      r.mpeg2 = (mode == MODE_M2);
      r.err   = err;
      due_outputs.push_back(r);
    endfunction

    function void reject(err_e code, logic [15:0] zeros);
      phase = P_HUNT;
      cnt   = zeros;
      route = RT_DROP;
      deliver(8'h00, ChanError, 1'b0, code);
    endfunction

    function void push_byte(logic [7:0] b);
      logic [15:0] zrun;
      logic [15:0] idx;
      logic        at_end;
      mode_e       m;
      zrun = (b == 8'h00) ? 16'd1 : 16'd0;
      case (phase)
        P_PFX0, P_PFX1: begin
          if (b != 8'h00) reject(ERR_START_CODE, 16'd0);
          else phase = (phase == P_PFX0) ? P_PFX1 : P_PFX2;
        end
        P_PFX2: begin
          if (b != 8'h01) reject(ERR_START_CODE, (b == 8'h00) ? 16'd2 : 16'd0);
          else phase = P_TAG;
        end
        P_HUNT: begin
          if (b == 8'h00) begin
            cnt = (cnt >= 16'd2) ? 16'd2 : cnt + 16'd1;
          end else if (b == 8'h01 && cnt >= 16'd2) begin
            cnt   = '0;
            phase = P_TAG;
          end else begin
            cnt = '0;
          end
        end
        P_TAG: begin
          tag   = b;
          route = RT_DROP;
          if (audio_sel == {1'b1, b}) begin
            phase = P_LEN_HI;
            if (audio_en) begin
              route = RT_AUDIO;
              deliver(b, ChanAudio, 1'b0, ERR_NONE);
            end
          end else if (video_sel == {1'b1, b}) begin
            phase = P_LEN_HI;
            if (video_en) begin
              route = RT_VIDEO;
              deliver(b, ChanVideo, 1'b0, ERR_NONE);
            end
          end else if (b == TagEnd) begin
            audio_sel = '0;
            video_sel = '0;
            mode      = MODE_NONE;
            phase     = P_PFX0;
          end else if (b == TagPack) begin
            cnt   = 16'd4;
            phase = P_PACK;
          end else if (b == TagSystem) begin
            if (mode == MODE_NONE) reject(ERR_NO_PACK, 16'd0);
            else phase = P_LEN_HI;
          end else if (b >= TagFirst) begin
            phase = P_LEN_HI;
          end else begin
            phase = P_PFX0;
          end
        end
        P_PACK: begin
          if (cnt == 16'd4) begin
            if ((b & Mpeg2Mask) == Mpeg2Val) begin
              m = MODE_M2;
            end else if ((b & Mpeg1Mask) == Mpeg1Val) begin
              m = MODE_M1;
            end else begin
              reject(ERR_MODE, zrun);
              return;
            end
            if (mode != MODE_NONE && mode != m) begin
              reject(ERR_MIXED, zrun);
              return;
            end
            mode = m;
          end
          if (mode == MODE_M1 && cnt >= 16'd11) begin
            phase = P_PFX0;
          end else if (mode == MODE_M2 && cnt >= 16'd13) begin
            stuff = 3'(b & StuffMask);
            phase = (stuff != 3'd0) ? P_STUFF : P_PFX0;
          end
          cnt = cnt + 16'd1;
        end
        P_STUFF: begin
          if (b != StuffByte) begin
            reject(ERR_STUFFING, zrun);
            return;
          end
          stuff = stuff - 3'd1;
          if (stuff == 3'd0) phase = P_PFX0;
        end
        P_LEN_HI: begin
          body_len = {b, 8'h00};
          phase    = P_LEN_LO;
          if (route != RT_DROP) deliver(b, route, 1'b0, ERR_NONE);
        end
        P_LEN_LO: begin
          body_len[7:0] = b;
          cnt           = '0;
          if (tag == TagSystem) begin
            if (body_len < 16'd6) reject(ERR_LEN_SHORT, zrun);
            else if (body_len % 3 != 0) reject(ERR_LEN_MOD3, zrun);
            else phase = P_BODY;
          end else if (body_len == 16'd0) begin
            reject(ERR_PES_ZERO, zrun);
          end else begin
            phase = P_BODY;
            if (route != RT_DROP) deliver(b, route, 1'b0, ERR_NONE);
          end
        end
        P_BODY: begin
          idx    = cnt;
          at_end = ({1'b0, idx} + 17'd1 >= {1'b0, body_len});
          cnt    = cnt + 16'd1;
          if (at_end) phase = P_PFX0;
          if (tag == TagSystem) begin
            if (idx >= 16'd6 && (idx - 16'd6) % 3 == 0) begin
              if (b >= AudioLo && b <= AudioHi && !audio_sel[8]) begin
                audio_sel = {1'b1, b};
              end else if (b >= VideoLo && b <= VideoHi && !video_sel[8]) begin
                video_sel = {1'b1, b};
              end
            end
          end else if (route != RT_DROP) begin
            deliver(b, route, at_end, ERR_NONE);
            if (at_end) route = RT_DROP;
          end
        end
        default: phase = P_PFX0;
      endcase
    endfunction

    task report(string what);
      fails++;
      if (fails <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_output(res_t got);
      res_t want;
      if (due_outputs.size() == 0) begin
        report($sformatf("unexpected item, byte %02h channel %0d error %0d",
                         got.data, got.chan, got.err));
        return;
      end
      want = due_outputs.pop_front();
      if (got.data !== want.data)
        report($sformatf("out_byte %02h, expected %02h", got.data, want.data));
      if (got.chan !== want.chan)
        report($sformatf("channel %0d, expected %0d", got.chan, want.chan));
      if (got.last !== want.last)
        report($sformatf("last_of_packet %0b, expected %0b", got.last, want.last));
      if (got.mpeg2 !== want.mpeg2)
        report($sformatf("is_mpeg2 %0b, expected %0b", got.mpeg2, want.mpeg2));
      if (got.err !== want.err)
        report($sformatf("error_code %0d, expected %0d", got.err, want.err));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic [1:0]  channel_o;
  logic        last_of_packet_o;
  logic        is_mpeg2_o;
  logic [3:0]  error_code_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  demux_mirror mirror;
  logic [7:0]  stream_q[$];
  mode_e       gen_mode;
  logic [8:0]  gen_audio;
  logic [8:0]  gen_video;
  logic        idle_on;
  logic        calm;
  logic [3:0]  ready_hold;
  int          quiet_cycles = 0;
  logic [1:0]  en_plan[5];

  program_stream_demux i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .stream_byte_i,
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .channel_o,
    .last_of_packet_o,
    .is_mpeg2_o,
    .error_code_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (ready_hold != 4'd0) begin
      ready_hold <= ready_hold - 4'd1;
    end else if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
      ready_hold  <= 4'($urandom_range(0, 13));
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) mirror.push_byte(stream_byte_i);
      if (out_valid_o && out_ready_i)
        mirror.check_output({out_byte_o, channel_o, last_of_packet_o, is_mpeg2_o,
                             error_code_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("== FAIL ==");
    $finish;
  end

  task automatic apb_write(input int unsigned idx, input logic value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= {31'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror.set_enable(idx, value);
  endtask

  task automatic feed_stream();
    logic [7:0] b;
    while (stream_q.size() != 0) begin
      b = stream_q.pop_front();
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      stream_byte_i <= b;
      do @(posedge clk_i); while (!in_ready_o);
    end
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic forget_stream();
    gen_mode  = MODE_NONE;
    gen_audio = '0;
    gen_video = '0;
  endtask

  task automatic put_prefix(input logic [7:0] tag);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h01);
    stream_q.push_back(tag);
  endtask

  task automatic put_pack(input logic m2, input logic bad_stuff);
    logic [2:0]  n;
    int unsigned bad_at;
    put_prefix(TagPack);
    if (m2) begin
      stream_q.push_back(Mpeg2Val | 8'($urandom_range(0, 63)));
      repeat (8) stream_q.push_back(8'($urandom));
      n = bad_stuff ? 3'($urandom_range(1, 7)) : 3'($urandom_range(0, 7));
      stream_q.push_back({5'($urandom), n});
      bad_at = $urandom_range(1, 7);
      for (int i = 1; i <= n; i++) begin
        if (bad_stuff && i == (bad_at % n) + 1) stream_q.push_back(8'($urandom_range(0, 254)));
        else stream_q.push_back(StuffByte);
      end
    end else begin
      stream_q.push_back(Mpeg1Val | 8'($urandom_range(0, 15)));
      repeat (7) stream_q.push_back(8'($urandom));
    end
  endtask

  task automatic put_system(input int unsigned entries);
    int unsigned len;
    logic [7:0]  id;
    len = 6 + 3 * entries;
    put_prefix(TagSystem);
    stream_q.push_back(8'(len >> 8));
    stream_q.push_back(8'(len));
    repeat (6) stream_q.push_back(8'($urandom));
    repeat (entries) begin
      case ($urandom_range(0, 4))
        0, 1: id = 8'($urandom_range(AudioLo, AudioHi));
        2, 3: id = 8'($urandom_range(VideoLo, VideoHi));
        default: id = 8'($urandom);
      endcase
      if (id >= AudioLo && id <= AudioHi && !gen_audio[8]) gen_audio = {1'b1, id};
      else if (id >= VideoLo && id <= VideoHi && !gen_video[8]) gen_video = {1'b1, id};
      stream_q.push_back(id);
      stream_q.push_back(8'($urandom));
      stream_q.push_back(8'($urandom));
    end
  endtask

  task automatic put_pes(input logic [7:0] id, input int unsigned len);
    put_prefix(id);
    stream_q.push_back(8'(len >> 8));
    stream_q.push_back(8'(len));
    repeat (len) stream_q.push_back(8'($urandom));
  endtask

  function automatic logic [7:0] pes_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && gen_audio[8]) return gen_audio[7:0];
    if (r < 8 && gen_video[8]) return gen_video[7:0];
    return 8'($urandom_range(TagFirst, 8'hFF));
  endfunction

  function automatic int unsigned pes_len();
    if ($urandom_range(0, 39) == 0) return $urandom_range(256, 300);
    return $urandom_range(1, 16);
  endfunction

  task automatic put_fault(input logic m2);
    logic [7:0] b;
    case ($urandom_range(0, 10))
      0: begin
        put_prefix(TagPack);
        do b = 8'($urandom);
        while ((b & Mpeg2Mask) == Mpeg2Val || (b & Mpeg1Mask) == Mpeg1Val);
        stream_q.push_back(b);
      end
      1: put_pack(!m2, 1'b0);
      2: put_pack(1'b1, 1'b1);
      3: begin
        put_prefix(TagSystem);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'($urandom_range(0, 5)));
      end
      4: begin
        put_prefix(TagSystem);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'(6 + 3 * $urandom_range(0, 4) + $urandom_range(1, 2)));
      end
      5: put_pes(pes_id(), 0);
      6: put_prefix(8'($urandom_range(0, TagEnd - 1)));
      7: begin
        stream_q.push_back(8'h00);
        put_pes(pes_id(), pes_len());
      end
      8: begin
        put_prefix(TagEnd);
        forget_stream();
        put_prefix(TagSystem);
      end
      9: begin
        put_prefix(pes_id());
        stream_q.push_back(8'h00);
      end
      default: begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: stream_q.push_back(8'h00);
            1: stream_q.push_back(8'h01);
            2: stream_q.push_back(StuffByte);
            default: stream_q.push_back(8'($urandom));
          endcase
        end
      end
    endcase
  endtask

  task automatic put_session();
    logic m2;
    m2 = (gen_mode == MODE_NONE) ? 1'($urandom_range(0, 1)) : (gen_mode == MODE_M2);
    if ($urandom_range(0, 3) == 0) put_fault(m2);
    put_pack(m2, 1'b0);
    gen_mode = m2 ? MODE_M2 : MODE_M1;
    put_system($urandom_range(1, 4));
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 11))
        0, 1, 2: put_fault(m2);
        3: put_pack(m2, 1'b0);
        default: put_pes(pes_id(), pes_len());
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      put_prefix(TagEnd);
      forget_stream();
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    stream_byte_i = 8'h00;
    out_ready_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    ready_hold    = 4'd0;
    idle_on       = 1'b1;
    calm          = 1'b0;
    en_plan       = '{2'b11, 2'b01, 2'b10, 2'b00, 2'b11};
    forget_stream();
    mirror = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      apb_write(RegAudioEnable, en_plan[p][1]);
      apb_write(RegVideoEnable, en_plan[p][0]);
      if (p == 0) begin
        // A zero run that breaks a prefix still counts toward the next one.
        stream_q.push_back(8'h00);
        put_prefix(TagEnd);
        stream_q.push_back(StuffByte);
        put_prefix(TagSystem);
        put_prefix(TagPack);
        stream_q.push_back(8'h80);
        put_prefix(8'h07);
      end
      if (p == 4) idle_on = 1'b0;
      while (stream_q.size() < PhaseBytes) put_session();
      feed_stream();
      drain_block();
    end

    if (mirror.fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
